/* sv/nv12pcm_pkg.sv */
package nv12pcm_pkg;

    // Field widths
    localparam int LUMA_W  = 8;
    localparam int CHROMA_W = 8;
    localparam int COL_W   = 12;
    localparam int RW_W    = 13;
    localparam int MASK_W  = 8;

    // Signed channel sums and clamped Q8.12 channels
    localparam int SUM_W = 24;
    localparam int CH_W  = 20;

    // Cycles from an accepted pixel to its result strobe
    localparam int LATENCY = 5;

    // Colour conversion coefficients, Q.12, signed
    localparam logic signed [15:0] K_LUMA = 16'sd4769;
    localparam logic signed [15:0] K_RV   = 16'sd7343;
    localparam logic signed [15:0] K_GU   = 16'sd873;
    localparam logic signed [15:0] K_GV   = 16'sd2183;
    localparam logic signed [15:0] K_BU   = 16'sd8652;

    // Classification ratios, Q.12, unsigned
    localparam logic [12:0] K_PINK_RG = 13'd6554;
    localparam logic [9:0]  K_PINK_BR = 10'd614;
    localparam logic [10:0] K_BMIN    = 11'd1843;

    // Left-part test factors
    localparam logic [8:0] COL_K = 9'd308;
    localparam logic [6:0] WID_K = 7'd120;

    // Thresholds scaled by 4096
    localparam logic [CH_W-1:0] CH_MAX  = 20'd1044480;
    localparam logic [CH_W-1:0] TH_R70  = 20'd286720;
    localparam logic [CH_W-1:0] TH_R140 = 20'd573440;
    localparam logic [CH_W-1:0] TH_G130 = 20'd532480;
    localparam logic [CH_W-1:0] TH_RB35 = 20'd143360;
    localparam logic [CH_W-1:0] TH_D80  = 20'd327680;
    localparam logic [CH_W-1:0] TH_D35  = 20'd143360;

    localparam logic [MASK_W-1:0] MASK_HIT  = 8'd255;
    localparam logic [MASK_W-1:0] MASK_MISS = 8'd0;

    // Clamp a signed channel sum to 0..255*4096
    function automatic logic [CH_W-1:0] clamp_ch(input logic signed [SUM_W-1:0] x);
        logic [CH_W-1:0] y;
        if (x < 0)
        begin
            y = '0;
        end
        else if (x > $signed({4'b0000, CH_MAX}))
        begin
            y = CH_MAX;
        end
        else
        begin
            y = x[CH_W-1:0];
        end
        return y;
    endfunction

endpackage

/* sv/nv12_pixel_color_mask_top.sv */
// Channel     | Handshake               | Payload
// ------------+-------------------------+-----------------------------------------
// pixel in    | start / busy            | luma_sample, cb_sample, cr_sample, column
// mask out    | done (one-cycle strobe) | mask_byte
// config      | region_width_we         | region_width_wdata
//
// One pixel per clock; busy is never raised. Each result strobes done once its pixel
// has passed the five register stages of the pipeline (products, channel sums and
// clamp, ratio products and compares, pink decision, final combine).
// Reset clears the stage valid bits and sets the region width to MAX_WIDTH.
// The receiver cannot stall, so no stage ever holds: every stage advances each cycle.
module nv12_pixel_color_mask_top #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [nv12pcm_pkg::LUMA_W-1:0]    luma_sample,
    input  logic [nv12pcm_pkg::CHROMA_W-1:0]  cb_sample,
    input  logic [nv12pcm_pkg::CHROMA_W-1:0]  cr_sample,
    input  logic [nv12pcm_pkg::COL_W-1:0]     column,
    output logic                              done,
    output logic [nv12pcm_pkg::MASK_W-1:0]    mask_byte,
    input  logic                              region_width_we,
    input  logic [nv12pcm_pkg::RW_W-1:0]      region_width_wdata
);
    import nv12pcm_pkg::*;

    // Configuration
    logic [RW_W-1:0] region_width_reg;

    // Stage valid bits
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, done_reg;
    logic s1_vld_next;

    // Stage 1: coefficient products
    logic signed [SUM_W-1:0] s1_lum_reg, s1_rv_reg, s1_guv_reg, s1_bu_reg;
    logic signed [SUM_W-1:0] s1_lum_next, s1_rv_next, s1_guv_next, s1_bu_next;
    logic [20:0] s1_colp_reg, s1_wp_reg, s1_colp_next, s1_wp_next;
    logic signed [8:0] y_s, u_s, v_s;

    // Stage 2: clamped channels
    logic [CH_W-1:0] s2_r_reg, s2_g_reg, s2_b_reg;
    logic [CH_W-1:0] s2_r_next, s2_g_next, s2_b_next;
    logic s2_left_reg, s2_left_next;

    // Stage 3: ratio products and simple compares
    logic [CH_W-1:0] s3_r_reg, s3_b_reg, s3_lo_reg;
    logic [CH_W-1:0] s3_r_next, s3_b_next, s3_lo_next;
    logic [32:0] s3_rg_reg, s3_rg_next;
    logic [29:0] s3_br_reg, s3_br_next;
    logic s3_left_reg, s3_r70_reg, s3_r140_reg, s3_g130_reg, s3_rb_reg;
    logic s3_d80_reg, s3_d35_reg;
    logic s3_r70_next, s3_r140_next, s3_g130_next, s3_rb_next, s3_d80_next, s3_d35_next;
    logic [CH_W-1:0] diff_rg;

    // Stage 4: pink decision, blue bound product
    logic s4_pink_reg, s4_warm_reg, s4_left_reg, s4_d80_reg, s4_d35_reg;
    logic s4_pink_next, s4_warm_next;
    logic [CH_W-1:0] s4_b_reg;
    logic [30:0] s4_bm_reg, s4_bm_next;

    // Stage 5: final combine
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic b_ok;

    assign busy = 1'b0;
    assign s1_vld_next = start && !busy;

    // Register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_width_reg <= RW_W'(MAX_WIDTH);
        end
        else if (region_width_we)
        begin
            region_width_reg <= region_width_wdata;
        end
    end

    // Stage 1 logic: centre samples and form the constant products
    always_comb
    begin
        y_s = $signed({1'b0, luma_sample}) - 9'sd16;
        u_s = $signed({1'b0, cb_sample}) - 9'sd128;
        v_s = $signed({1'b0, cr_sample}) - 9'sd128;
        s1_lum_next = SUM_W'(y_s) * SUM_W'(K_LUMA);
        s1_rv_next  = SUM_W'(v_s) * SUM_W'(K_RV);
        s1_guv_next = SUM_W'(u_s) * SUM_W'(K_GU) + SUM_W'(v_s) * SUM_W'(K_GV);
        s1_bu_next  = SUM_W'(u_s) * SUM_W'(K_BU);
        s1_colp_next = 21'(column) * 21'(COL_K);
        s1_wp_next   = 21'(region_width_reg) * 21'(WID_K);
    end

    // Stage 2 logic: channel sums, clamp, left-part test
    always_comb
    begin
        s2_r_next = clamp_ch(s1_lum_reg + s1_rv_reg);
        s2_g_next = clamp_ch(s1_lum_reg - s1_guv_reg);
        s2_b_next = clamp_ch(s1_lum_reg + s1_bu_reg);
        s2_left_next = s1_colp_reg < s1_wp_reg;
    end

    // Stage 3 logic: min, difference, ratio products, thresholds
    always_comb
    begin
        if (s2_r_reg >= s2_g_reg)
        begin
            diff_rg    = s2_r_reg - s2_g_reg;
            s3_lo_next = s2_g_reg;
        end
        else
        begin
            diff_rg    = s2_g_reg - s2_r_reg;
            s3_lo_next = s2_r_reg;
        end
        s3_r_next    = s2_r_reg;
        s3_b_next    = s2_b_reg;
        s3_rg_next   = 33'(s2_g_reg) * 33'(K_PINK_RG);
        s3_br_next   = 30'(s2_r_reg) * 30'(K_PINK_BR);
        s3_r70_next  = s2_r_reg > TH_R70;
        s3_r140_next = s2_r_reg > TH_R140;
        s3_g130_next = s2_g_reg > TH_G130;
        s3_rb_next   = 21'(s2_r_reg) > (21'(s2_b_reg) + 21'(TH_RB35));
        s3_d80_next  = diff_rg < TH_D80;
        s3_d35_next  = diff_rg < TH_D35;
    end

    // Stage 4 logic: pink decision and the blue bound for warm tones
    always_comb
    begin
        s4_pink_next = s3_left_reg && s3_r70_reg && s3_rb_reg
                    && (33'({s3_r_reg, 12'b0}) > s3_rg_reg)
                    && ({s3_b_reg, 12'b0} > 32'(s3_br_reg));
        s4_warm_next = s3_r140_reg && s3_g130_reg;
        s4_bm_next   = 31'(s3_lo_reg) * 31'(K_BMIN);
    end

    // Stage 5 logic: gold and yellow, merge into the mask byte
    always_comb
    begin
        b_ok = {s4_b_reg, 12'b0} < 32'(s4_bm_reg);
        if (s4_pink_reg
            || (s4_warm_reg && b_ok && s4_d35_reg)
            || (s4_warm_reg && b_ok && s4_d80_reg && s4_left_reg))
        begin
            mask_next = MASK_HIT;
        end
        else
        begin
            mask_next = MASK_MISS;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            done_reg   <= s4_vld_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        s1_lum_reg  <= s1_lum_next;
        s1_rv_reg   <= s1_rv_next;
        s1_guv_reg  <= s1_guv_next;
        s1_bu_reg   <= s1_bu_next;
        s1_colp_reg <= s1_colp_next;
        s1_wp_reg   <= s1_wp_next;

        s2_r_reg    <= s2_r_next;
        s2_g_reg    <= s2_g_next;
        s2_b_reg    <= s2_b_next;
        s2_left_reg <= s2_left_next;

        s3_r_reg    <= s3_r_next;
        s3_b_reg    <= s3_b_next;
        s3_lo_reg   <= s3_lo_next;
        s3_rg_reg   <= s3_rg_next;
        s3_br_reg   <= s3_br_next;
        s3_left_reg <= s2_left_reg;
        s3_r70_reg  <= s3_r70_next;
        s3_r140_reg <= s3_r140_next;
        s3_g130_reg <= s3_g130_next;
        s3_rb_reg   <= s3_rb_next;
        s3_d80_reg  <= s3_d80_next;
        s3_d35_reg  <= s3_d35_next;

        s4_pink_reg <= s4_pink_next;
        s4_warm_reg <= s4_warm_next;
        s4_left_reg <= s3_left_reg;
        s4_d80_reg  <= s3_d80_reg;
        s4_d35_reg  <= s3_d35_reg;
        s4_b_reg    <= s3_b_reg;
        s4_bm_reg   <= s4_bm_next;

        mask_reg    <= mask_next;
    end

    assign done      = done_reg;
    assign mask_byte = mask_reg;

endmodule

/* sv/nv12pcm_checker.sv */
module nv12pcm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic [nv12pcm_pkg::MASK_W-1:0] mask_byte
);
    import nv12pcm_pkg::*;

    // Every result strobe traces back to a transaction a fixed latency earlier
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching input transaction");

    // Every transaction taken out of reset yields its result after the latency
    a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(start && !busy, LATENCY) && $past(rst_n, LATENCY)
         && $past(rst_n, 4) && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1))
        |-> done)
        else $error("input transaction produced no result");

    // The mask is all ones or all zeros
    a_mask_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (mask_byte == MASK_HIT || mask_byte == MASK_MISS))
        else $error("mask byte neither hit nor miss");

endmodule

bind nv12_pixel_color_mask_top nv12pcm_checker u_nv12pcm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .mask_byte (mask_byte)
);
